[sv/tcw_pkg.sv]
// Shared types and constants for the text console writer.
package tcw_pkg;

  localparam logic [7:0] ESC_BYTE      = 8'h1B;
  localparam logic [7:0] LF_BYTE       = 8'h0A;
  localparam logic [7:0] CR_BYTE       = 8'h0D;
  localparam logic [7:0] TAB_BYTE      = 8'h09;
  localparam logic [7:0] LBRK_BYTE     = 8'h5B;
  localparam logic [7:0] SEMI_BYTE     = 8'h3B;
  localparam logic [7:0] M_BYTE        = 8'h6D;
  localparam logic [7:0] ZERO_BYTE     = 8'h30;
  localparam logic [7:0] SEVEN_BYTE    = 8'h37;
  localparam logic [7:0] THREE_BYTE    = 8'h33;
  localparam logic [7:0] NINE_BYTE     = 8'h39;
  localparam logic [7:0] SPACE_BYTE    = 8'h20;
  localparam logic [7:0] WHITE_COLOR   = 8'h0F;
  localparam logic [7:0] BRIGHT_OFFSET = 8'h08;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  typedef enum logic [2:0] {
    ST_INIT,   // clear pass after reset
    ST_IDLE,
    ST_CLEAR,  // fill with spaces in current color
    ST_READ,   // read data returns
    ST_PLAIN,  // process pending byte, plain or escape
    ST_OUT     // result waits in output register
  } state_t;

endpackage

[sv/tcw_ram.sv]
// Generic single-port RAM with registered read.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[sv/text_console_writer_top.sv]
// Top level of the text console writer: cursor, color, escape parser, cell RAM.
//
//  channel | signals                          | fields (low bit up)
//  in      | in_tvalid in_tready in_tdata     | data_byte[7:0], cell_address[18:8]
//          | in_tuser                         | action[0], first_of_call[1]
//  out     | out_tvalid out_tready out_tdata  | cell_value, row, column, color, esc
//
// A byte or a read passes accept (ST_IDLE), process or RAM read (ST_PLAIN or
// ST_READ) and result (ST_OUT); an escape that re-feeds a '0' visits ST_PLAIN
// twice. A write call that starts at 0,0 walks all ROWS*COLUMNS cells, one
// per cycle, before the byte. After reset the same clear pass runs before in_tready.
// The output register holds a result until out_tready; no item is taken then.
module text_console_writer_top
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // data_byte[7:0], cell_address[18:8], zero
  input  logic [1:0]  in_tuser,   // action[0], first_of_call[1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // cell_value[15:0], cursor_row[20:16],
                                  // cursor_column[27:21], current_color[35:28],
                                  // escape_pending[36], zero
);
  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);

  state_t state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [4:0] row_r, row_nxt;
  logic [6:0] col_r, col_nxt;
  logic [7:0] attr_r, attr_nxt;
  logic [2:0] ecnt_r, ecnt_nxt;
  logic [7:0] ex_r, ex_nxt, ey_r, ey_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       first_r, first_nxt;
  logic [15:0] val_r, val_nxt;
  logic        rd_ok_r, rd_ok_nxt;

  logic          we;
  logic [AW-1:0] addr;
  logic [15:0]   wdata, rdata;

  tcw_ram #(.WIDTH(16), .DEPTH(CELLS)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  // Cell index of the cursor
  logic [AW-1:0] cur_idx;
  assign cur_idx = AW'(32'(row_r) * COLUMNS + 32'(col_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      clr_r   <= '0;
      row_r   <= '0;
      col_r   <= '0;
      attr_r  <= WHITE_COLOR;
      ecnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      attr_r  <= attr_nxt;
      ecnt_r  <= ecnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ex_r    <= ex_nxt;
    ey_r    <= ey_nxt;
    byte_r  <= byte_nxt;
    first_r <= first_nxt;
    val_r   <= val_nxt;
    rd_ok_r <= rd_ok_nxt;
  end

  // Sequencer; each plain byte may write one cell
  always_comb begin
    logic [7:0] b;
    logic       do_plain;
    logic       adv_row;
    state_nxt = state_r;
    clr_nxt   = clr_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    attr_nxt  = attr_r;
    ecnt_nxt  = ecnt_r;
    ex_nxt    = ex_r;
    ey_nxt    = ey_r;
    byte_nxt  = byte_r;
    first_nxt = first_r;
    val_nxt   = val_r;
    rd_ok_nxt = rd_ok_r;
    we        = 1'b0;
    addr      = cur_idx;
    wdata     = {attr_r, byte_r};
    in_tready = 1'b0;
    b         = byte_r;
    do_plain  = 1'b0;
    adv_row   = 1'b0;

    unique case (state_r)
      ST_INIT, ST_CLEAR: begin
        we    = 1'b1;
        addr  = clr_r;
        wdata = (state_r == ST_INIT) ? {WHITE_COLOR, SPACE_BYTE} : {attr_r, SPACE_BYTE};
        clr_nxt = clr_r + 1'b1;
        if (32'(clr_r) == CELLS - 1) begin
          clr_nxt   = '0;
          state_nxt = (state_r == ST_INIT) ? ST_IDLE : ST_PLAIN;
          first_nxt = 1'b0;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        addr      = AW'(in_tdata[18:8]);
        if (in_tvalid) begin
          if (in_tuser[0] == ACT_READ) begin
            rd_ok_nxt = 32'(in_tdata[18:8]) < CELLS;
            state_nxt = ST_READ;
          end else begin
            byte_nxt  = in_tdata[7:0];
            first_nxt = in_tuser[1];
            state_nxt = ST_PLAIN;
          end
          val_nxt = '0;
        end
      end
      ST_READ: begin
        val_nxt   = rd_ok_r ? rdata : 16'h0;
        state_nxt = ST_OUT;
      end
      ST_PLAIN: begin
        if (first_r && row_r == '0 && col_r == '0) begin
          state_nxt = ST_CLEAR;
        end else begin
          state_nxt = ST_OUT;
          case (ecnt_r)
            3'd0: do_plain = 1'b1;
            3'd1: ecnt_nxt = (b == LBRK_BYTE) ? 3'd2 : 3'd0;
            3'd2: begin
              if (b == ZERO_BYTE) ecnt_nxt = 3'd3;
              else begin
                ecnt_nxt = 3'd0;
                do_plain = 1'b1;
              end
            end
            3'd3: begin
              if (b == SEMI_BYTE) ecnt_nxt = 3'd4;
              else if (b == M_BYTE) begin
                attr_nxt = WHITE_COLOR;
                ecnt_nxt = 3'd0;
              end else begin
                // write the held '0' now, re-feed this byte next cycle
                ecnt_nxt  = 3'd0;
                b         = ZERO_BYTE;
                do_plain  = 1'b1;
                first_nxt = 1'b0;
                state_nxt = ST_PLAIN;
              end
            end
            3'd4: begin
              ex_nxt   = b;
              ecnt_nxt = 3'd5;
            end
            3'd5: begin
              ey_nxt   = b;
              ecnt_nxt = 3'd6;
            end
            default: begin
              ecnt_nxt = 3'd0;
              if (b == M_BYTE) begin
                if ((ex_r == THREE_BYTE || ex_r == NINE_BYTE) &&
                    ey_r >= ZERO_BYTE && ey_r <= SEVEN_BYTE) begin
                  attr_nxt = ((ex_r == NINE_BYTE) ? BRIGHT_OFFSET : 8'h00) +
                             (ey_r - ZERO_BYTE);
                end
              end else begin
                do_plain = 1'b1;
              end
            end
          endcase

          if (do_plain) begin
            if (b == LF_BYTE) begin
              adv_row = 1'b1;
              col_nxt = '0;
            end else if (b == CR_BYTE || b == TAB_BYTE) begin
              col_nxt = col_r;
            end else if (b == ESC_BYTE) begin
              ecnt_nxt = 3'd1;
            end else begin
              we    = 1'b1;
              wdata = {attr_r, b};
              if (32'(col_r) == COLUMNS - 1) begin
                col_nxt = '0;
                adv_row = 1'b1;
              end else begin
                col_nxt = col_r + 1'b1;
              end
            end
            if (adv_row) begin
              row_nxt = (32'(row_r) == ROWS - 1) ? 5'd0 : row_r + 1'b1;
            end
          end
        end
      end
      ST_OUT: begin
        if (out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = {3'b000, (ecnt_r != 3'd0), attr_r, col_r, row_r, val_r};

  // Checks
  always_ff @(posedge clk) begin
    if (rst_n) begin
      assert (32'(col_r) < COLUMNS) else $error("column out of range");
      assert (32'(row_r) < ROWS) else $error("row out of range");
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while result held");
  a_esc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ecnt_r <= 3'd6) else $error("escape count overflow");
  a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INIT || state_r == ST_CLEAR) |-> !out_tvalid && !in_tready)
    else $error("handshake during clear pass");
endmodule

[tb/sv/text_console_writer_checker.sv]
// Checker for the text console writer: tracks console state and compares results.
`timescale 1ns / 1ps
module text_console_writer_checker
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  output int          fail_count,
  output int          pending_count,
  output int          result_count
);

  localparam int CELLS = ROWS * COLUMNS;

  // packed from the top bit down; value lands in bits 15:0
  typedef struct packed {
    logic        esc;
    logic [7:0]  color;
    logic [6:0]  col;
    logic [4:0]  row;
    logic [15:0] value;
  } console_result_t;

  // shadow console state
  logic [15:0] screen [CELLS];
  int unsigned cur_row, cur_col;
  logic [7:0]  color;
  logic [7:0]  esc_x, esc_y;
  int unsigned esc_stage;
  console_result_t expected_results[$];

  assign pending_count = expected_results.size();

  task automatic advance_row();
    cur_row = (cur_row + 1 >= ROWS) ? 0 : cur_row + 1;
  endtask

  task automatic put_plain(input logic [7:0] b);
    if (b == LF_BYTE) begin
      advance_row();
      cur_col = 0;
    end else if (b == CR_BYTE || b == TAB_BYTE) begin
    end else if (b == ESC_BYTE) begin
      esc_stage = 1;
    end else begin
      screen[cur_row * COLUMNS + cur_col] = {color, b};
      cur_col++;
      if (cur_col >= COLUMNS) begin
        cur_col = 0;
        advance_row();
      end
    end
  endtask

  task automatic take_console_byte(input logic [7:0] b);
    case (esc_stage)
      0: put_plain(b);
      1: esc_stage = (b == LBRK_BYTE) ? 2 : 0;
      2: begin
        if (b == ZERO_BYTE) esc_stage = 3;
        else begin
          esc_stage = 0;
          put_plain(b);
        end
      end
      3: begin
        if (b == SEMI_BYTE) esc_stage = 4;
        else if (b == M_BYTE) begin
          color = WHITE_COLOR;
          esc_stage = 0;
        end else begin
          esc_stage = 0;
          put_plain(ZERO_BYTE);
          put_plain(b);
        end
      end
      4: begin
        esc_x = b;
        esc_stage = 5;
      end
      5: begin
        esc_y = b;
        esc_stage = 6;
      end
      default: begin
        esc_stage = 0;
        if (b == M_BYTE) begin
          if ((esc_x == THREE_BYTE || esc_x == NINE_BYTE) &&
              esc_y >= ZERO_BYTE && esc_y <= SEVEN_BYTE)
            color = ((esc_x == NINE_BYTE) ? BRIGHT_OFFSET : 8'h00) + (esc_y - ZERO_BYTE);
        end else put_plain(b);
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  // predict on each input transfer, compare on each output transfer
  always @(posedge clk) begin
    console_result_t r, e;
    logic [10:0] addr;
    if (!rst_n) begin
      foreach (screen[k]) screen[k] = {WHITE_COLOR, SPACE_BYTE};
      cur_row = 0;
      cur_col = 0;
      color = WHITE_COLOR;
      esc_stage = 0;
      fail_count = 0;
      result_count = 0;
      expected_results.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        e.value = '0;
        addr = in_tdata[18:8];
        if (in_tuser[0] == ACT_WRITE) begin
          if (in_tuser[1] && cur_row == 0 && cur_col == 0)
            foreach (screen[k]) screen[k] = {color, SPACE_BYTE};
          take_console_byte(in_tdata[7:0]);
        end else if (addr < CELLS) e.value = screen[addr];
        e.row = 5'(cur_row);
        e.col = 7'(cur_col);
        e.color = color;
        e.esc = (esc_stage != 0);
        expected_results.push_back(e);
      end
      if (out_tvalid && out_tready) begin
        r = out_tdata[36:0];
        result_count++;
        if (expected_results.size() == 0) begin
          $display("ERROR %0t: result with no item outstanding", $time);
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          if (r.value != e.value) report_mismatch("cell_value", r.value, e.value);
          if (r.row != e.row) report_mismatch("cursor_row", 16'(r.row), 16'(e.row));
          if (r.col != e.col) report_mismatch("cursor_column", 16'(r.col), 16'(e.col));
          if (r.color != e.color)
            report_mismatch("current_color", 16'(r.color), 16'(e.color));
          if (r.esc != e.esc) report_mismatch("escape_pending", 16'(r.esc), 16'(e.esc));
        end
      end
    end
  end

endmodule

[tb/sv/text_console_writer_top_tb.sv]
// Testbench top: clock, reset, console byte and cell read stimulus, verdict.
`timescale 1ns / 1ps
module text_console_writer_top_tb;
  import tcw_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CYCLE_LIMIT = 5000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  int          fail_count, pending_count, result_count;
  int          cycle_count = 0;
  int          writes_sent = 0, reads_sent = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  text_console_writer_top #(.COLUMNS(COLUMNS), .ROWS(ROWS)) DUT (.*);

  text_console_writer_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_checker (.*);

  // receiver stalls: alternate ready phases and random stalls
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst_n) out_tready <= 1'b0;
    else if ((cycle_count / 300) % 3 == 0) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  // timeout guard
  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // one transfer; idle gap first when asked
  task automatic send_item(input logic act, input logic [7:0] b, input logic first,
                           input logic [10:0] addr, input int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, addr, b};
    in_tuser <= {first, act};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (act == ACT_WRITE) writes_sent++;
    else reads_sent++;
  endtask

  task automatic put_byte(input logic [7:0] b, input logic first = 1'b0);
    send_item(ACT_WRITE, b, first, 11'($urandom), 0);
  endtask

  task automatic read_cell(input logic [10:0] addr);
    send_item(ACT_READ, 8'($urandom), 1'($urandom), addr, 0);
  endtask

  // pick a random console byte, biased toward escape content
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return LF_BYTE;
      1: return ESC_BYTE;
      2: return M_BYTE;
      3: return 8'($urandom_range(8'h30, 8'h39));
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    int burst, gap, kind;
    logic [7:0] x, y;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: clear, plain text, controls, escape forms, reads
    put_byte("A", 1'b1);
    put_byte(8'hFF);
    put_byte(8'h00);
    put_byte(CR_BYTE);
    put_byte(TAB_BYTE);
    put_byte(LF_BYTE);
    put_byte(ESC_BYTE); put_byte(LBRK_BYTE); put_byte(ZERO_BYTE); put_byte(M_BYTE);
    put_byte(ESC_BYTE); put_byte(LBRK_BYTE); put_byte(ZERO_BYTE); put_byte(SEMI_BYTE);
    put_byte(NINE_BYTE); put_byte(SEVEN_BYTE, 1'b1); put_byte(M_BYTE);
    put_byte(ESC_BYTE); put_byte(8'h41);
    put_byte(ESC_BYTE); put_byte(LBRK_BYTE); put_byte(8'h42);
    put_byte(ESC_BYTE); put_byte(LBRK_BYTE); put_byte(ZERO_BYTE); put_byte(8'h43);
    read_cell(11'd0);
    read_cell(11'd80);
    read_cell(11'(ROWS * COLUMNS - 1));
    read_cell(11'(ROWS * COLUMNS));
    read_cell(11'h7FF);

    // random: mostly escape sequences and text, bursty sender
    while (writes_sent + reads_sent < 525) begin
      burst = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      repeat (burst) begin
        kind = $urandom_range(0, 9);
        if (kind < 3) begin
          read_cell(($urandom_range(0, 7) == 0) ? 11'($urandom)
                                                : 11'($urandom_range(0, ROWS * COLUMNS - 1)));
        end else if (kind < 5) begin
          x = ($urandom_range(0, 3) == 0) ? pick_byte()
                                          : (($urandom_range(0, 1)) ? THREE_BYTE : NINE_BYTE);
          y = ($urandom_range(0, 3) == 0) ? pick_byte() : 8'($urandom_range(8'h30, 8'h38));
          put_byte(ESC_BYTE); put_byte(LBRK_BYTE); put_byte(ZERO_BYTE);
          if ($urandom_range(0, 4) == 0) put_byte(M_BYTE);
          else begin
            put_byte(SEMI_BYTE); put_byte(x); put_byte(y);
            put_byte(($urandom_range(0, 5) == 0) ? pick_byte() : M_BYTE);
          end
        end else if (kind == 5) begin
          // long text run to walk the cursor through wraps
          repeat ($urandom_range(20, 90)) put_byte(8'($urandom_range(8'h20, 8'h7E)));
        end else begin
          put_byte(pick_byte(), ($urandom_range(0, 7) == 0));
        end
      end
    end
    in_tvalid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d console byte writes and %0d cell reads, %0d results checked",
             writes_sent, reads_sent, result_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
sv/tcw_pkg.sv
sv/tcw_ram.sv
sv/text_console_writer_top.sv
tb/sv/text_console_writer_checker.sv
tb/sv/text_console_writer_top_tb.sv
